[rtl/core/sfa_pkg.sv]
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared constants, codes and types of the swap frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

    // sizes of the allocator
    localparam int NUM_FILES       = 4;
    localparam int FRAMES_PER_FILE = 64;
    localparam int MAX_PROCS       = 16;
    localparam int MAX_PAGES       = 64;

    // derived widths
    localparam int FILE_W   = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
    localparam int FRAME_W  = $clog2(FRAMES_PER_FILE);
    localparam int PROC_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PAGE_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W   = $clog2(MAX_PAGES + 1);
    localparam int COUNT_W  = $clog2(FRAMES_PER_FILE + 1);
    localparam int NF_W     = $clog2(NUM_FILES + 1);
    localparam int SLOT_AW  = PROC_W + PAGE_W;
    localparam int SLOT_DW  = FRAME_W + 1;
    localparam int SLOT_DEPTH = 2 ** SLOT_AW;

    // bitmap is counted one chunk per cycle
    localparam int CHUNK_W    = 8;
    localparam int NUM_CHUNKS = FRAMES_PER_FILE / CHUNK_W;
    localparam int CH_W       = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int PC_W       = $clog2(CHUNK_W + 1);

    // port field widths
    localparam int CMD_W    = 3;
    localparam int PID_W    = 16;
    localparam int PGN_W    = 6;
    localparam int STATUS_W = 3;
    localparam int FIDX_W   = 2;
    localparam int FRIDX_W  = 6;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PAGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNWRITTEN  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd5;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FPP   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FILES = 2'd2;

    typedef struct packed {
        logic        dyn;
        logic [6:0]  fpp;
        logic [2:0]  files;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [PID_W-1:0] process_id;
        logic [PGN_W-1:0] page_number;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   file_index;
        logic [FRIDX_W-1:0]  frame_index;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

endpackage

`default_nettype wire

[rtl/core/sfa_ram.sv]
// ----------------------------------------------------------------------------
// sfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/sfa_engine.sv]
// ----------------------------------------------------------------------------
// sfa_engine
// Command sequencer: process table, bitmap row and slot memory traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sfa_pkg::cfg_t           cfg,
    input  wire logic                    go,
    input  wire sfa_pkg::req_t           req,
    input  wire logic                    take,
    output sfa_pkg::eng_stat_t           stat,
    output sfa_pkg::res_t                res,
    output logic                         map_we,
    output logic [sfa_pkg::FILE_W-1:0]   map_waddr,
    output logic [sfa_pkg::FRAMES_PER_FILE-1:0] map_wdata,
    output logic [sfa_pkg::FILE_W-1:0]   map_raddr,
    input  wire logic [sfa_pkg::FRAMES_PER_FILE-1:0] map_rdata,
    output logic                         slot_we,
    output logic [sfa_pkg::SLOT_AW-1:0]  slot_waddr,
    output logic [sfa_pkg::SLOT_DW-1:0]  slot_wdata,
    output logic [sfa_pkg::SLOT_AW-1:0]  slot_raddr,
    input  wire logic [sfa_pkg::SLOT_DW-1:0] slot_rdata
);
    import sfa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_FIND, S_ROOM_RD, S_ROOM_WAIT, S_ROOM_CNT,
        S_ROW_RD, S_ROW_WAIT, S_ALLOC, S_ROW_WB,
        S_CLOSE_RD, S_CLOSE_WAIT, S_WR_RD, S_WR_WAIT,
        S_PG_RD, S_PG_WAIT, S_SH_RD, S_SH_WAIT, S_TAIL, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [PID_W-1:0]       pid_reg;
    logic [PGN_W-1:0]       page_reg;
    logic                   dyn_reg;

    // process table
    logic [MAX_PROCS-1:0]   proc_valid_reg;
    logic [MAX_PROCS-1:0]   proc_has_file_reg;
    logic [PID_W-1:0]       proc_ident_reg [MAX_PROCS];
    logic [FILE_W-1:0]      proc_file_reg [MAX_PROCS];
    logic [PCNT_W-1:0]      proc_count_reg [MAX_PROCS];

    logic [NUM_FILES-1:0]   row_valid_reg;

    logic [PROC_W-1:0]      p_reg;
    logic [FILE_W-1:0]      f_reg;
    logic [FILE_W-1:0]      best_reg;
    logic [COUNT_W-1:0]     bestc_reg;
    logic [COUNT_W-1:0]     cnt_reg;
    logic [CH_W-1:0]        ch_reg;
    logic [FRAMES_PER_FILE-1:0] word_reg;
    logic [FRAME_W-1:0]     b_reg;
    logic [PCNT_W-1:0]      left_reg;
    logic [PCNT_W-1:0]      si_reg;
    logic [PCNT_W-1:0]      i_reg;
    logic [FRAME_W-1:0]     first_reg;
    logic                   found_reg;
    logic [FRAME_W-1:0]     fr_reg;
    logic [FILE_W-1:0]      row_reg;
    res_t                   res_reg;

    logic [PCNT_W-1:0]      need_w;
    logic [NF_W-1:0]        nf_w;
    logic [PCNT_W-1:0]      cur_count;
    logic [FILE_W-1:0]      cur_file;
    logic                   last_p;
    logic                   match;
    logic [FRAMES_PER_FILE-1:0] q_room;
    logic [FRAMES_PER_FILE-1:0] q_row;
    logic [PC_W-1:0]        chunk_free;
    logic [COUNT_W-1:0]     room_tot;
    logic                   room_take;
    logic [FILE_W-1:0]      best_n;
    logic [COUNT_W-1:0]     bestc_n;
    logic                   f_last;
    logic [FRAME_W-1:0]     q_frame;
    logic                   q_unw;
    logic                   alloc_hit;
    logic                   alloc_end;
    logic                   i_last;

    // free bits in one chunk of a bitmap row
    function automatic logic [PC_W-1:0] free_ones(input logic [CHUNK_W-1:0] v);
        logic [PC_W-1:0] c;
        c = '0;
        for (int k = 0; k < CHUNK_W; k++)
        begin
            c = c + PC_W'(~v[k]);
        end
        return c;
    endfunction

    // register limits as they act on the block
    always_comb
    begin
        if (32'(cfg.fpp) > MAX_PAGES)
            need_w = PCNT_W'(MAX_PAGES);
        else
            need_w = PCNT_W'(cfg.fpp);
        if (cfg.files == 3'd0)
            nf_w = NF_W'(1);
        else if (32'(cfg.files) > NUM_FILES)
            nf_w = NF_W'(NUM_FILES);
        else
            nf_w = NF_W'(cfg.files);
    end

    // selected process entry and scan state
    assign cur_count = proc_count_reg[p_reg];
    assign cur_file  = proc_file_reg[p_reg];
    assign last_p    = (p_reg == PROC_W'(MAX_PROCS - 1));
    assign match     = proc_valid_reg[p_reg] && (proc_ident_reg[p_reg] == pid_reg);
    assign i_last    = ((32'(i_reg) + 1) == 32'(cur_count));

    // bitmap rows that were never written read as all free
    assign q_room = row_valid_reg[f_reg]   ? map_rdata : '0;
    assign q_row  = row_valid_reg[row_reg] ? map_rdata : '0;

    // roomiest file search
    assign chunk_free = free_ones(word_reg[ch_reg*CHUNK_W +: CHUNK_W]);
    assign room_tot   = cnt_reg + COUNT_W'(chunk_free);
    assign room_take  = (f_reg == '0) || (room_tot > bestc_reg);
    assign best_n     = room_take ? f_reg : best_reg;
    assign bestc_n    = room_take ? room_tot : bestc_reg;
    assign f_last     = ((32'(f_reg) + 1) == 32'(nf_w));

    // slot read data
    assign q_frame = slot_rdata[FRAME_W-1:0];
    assign q_unw   = slot_rdata[FRAME_W];

    // frame scan of one bitmap row
    assign alloc_hit = (left_reg != '0) && !word_reg[b_reg];
    assign alloc_end = (b_reg == FRAME_W'(FRAMES_PER_FILE - 1)) || (left_reg == '0)
                       || (alloc_hit && (left_reg == PCNT_W'(1)));

    // memory ports
    always_comb
    begin
        map_we     = (state_reg == S_ROW_WB);
        map_waddr  = row_reg;
        map_wdata  = word_reg;
        map_raddr  = (state_reg == S_ROOM_RD) ? f_reg : row_reg;

        slot_raddr = {p_reg, i_reg[PAGE_W-1:0]};
        if (state_reg == S_SH_RD)
            slot_raddr = {p_reg, PAGE_W'(i_reg + PCNT_W'(1))};

        slot_we    = 1'b0;
        slot_waddr = {p_reg, i_reg[PAGE_W-1:0]};
        slot_wdata = {1'b0, q_frame};
        case (state_reg)
            S_ALLOC:
            begin
                slot_we    = alloc_hit;
                slot_waddr = {p_reg, si_reg[PAGE_W-1:0]};
                slot_wdata = {(cmd_reg == CMD_START), b_reg};
            end
            S_WR_WAIT:
            begin
                slot_we = q_unw;
            end
            S_PG_WAIT:
            begin
                slot_we = (cmd_reg == CMD_WRITE);
            end
            S_SH_WAIT:
            begin
                slot_we    = 1'b1;
                slot_wdata = slot_rdata;
            end
            S_TAIL:
            begin
                slot_we    = !dyn_reg;
                slot_waddr = {p_reg, PAGE_W'(cur_count - PCNT_W'(1))};
                slot_wdata = {1'b1, fr_reg};
            end
            default:
            begin
                slot_we = 1'b0;
            end
        endcase
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign res       = res_reg;

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cmd_reg           <= '0;
            pid_reg           <= '0;
            page_reg          <= '0;
            dyn_reg           <= 1'b0;
            proc_valid_reg    <= '0;
            proc_has_file_reg <= '0;
            for (int k = 0; k < MAX_PROCS; k++)
            begin
                proc_ident_reg[k] <= '0;
                proc_file_reg[k]  <= '0;
                proc_count_reg[k] <= '0;
            end
            row_valid_reg <= '0;
            p_reg         <= '0;
            f_reg         <= '0;
            best_reg      <= '0;
            bestc_reg     <= '0;
            cnt_reg       <= '0;
            ch_reg        <= '0;
            word_reg      <= '0;
            b_reg         <= '0;
            left_reg      <= '0;
            si_reg        <= '0;
            i_reg         <= '0;
            first_reg     <= '0;
            found_reg     <= 1'b0;
            fr_reg        <= '0;
            row_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        cmd_reg  <= req.command;
                        pid_reg  <= req.process_id;
                        page_reg <= req.page_number;
                        dyn_reg  <= cfg.dyn;
                        p_reg    <= '0;
                        res_reg  <= '0;
                        if (req.command == CMD_CLEAR)
                        begin
                            row_valid_reg     <= '0;
                            proc_valid_reg    <= '0;
                            proc_has_file_reg <= '0;
                            for (int k = 0; k < MAX_PROCS; k++)
                            begin
                                proc_count_reg[k] <= '0;
                            end
                            state_reg <= S_DONE;
                        end
                        else if (req.command > CMD_CLEAR)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_FIND;
                    end
                end

                // one table entry per cycle
                S_FIND:
                begin
                    if (cmd_reg == CMD_START)
                    begin
                        if (!proc_valid_reg[p_reg])
                        begin
                            if (dyn_reg)
                            begin
                                proc_valid_reg[p_reg]    <= 1'b1;
                                proc_ident_reg[p_reg]    <= pid_reg;
                                proc_has_file_reg[p_reg] <= 1'b0;
                                proc_file_reg[p_reg]     <= '0;
                                proc_count_reg[p_reg]    <= '0;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                f_reg     <= '0;
                                state_reg <= S_ROOM_RD;
                            end
                        end
                        else if (last_p)
                        begin
                            res_reg.status <= ST_TABLE_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                            p_reg <= p_reg + PROC_W'(1);
                    end
                    else if (match)
                    begin
                        case (cmd_reg)
                            CMD_CLOSE:
                            begin
                                if (proc_has_file_reg[p_reg])
                                begin
                                    row_reg   <= cur_file;
                                    state_reg <= S_ROW_RD;
                                end
                                else
                                begin
                                    proc_valid_reg[p_reg]    <= 1'b0;
                                    proc_has_file_reg[p_reg] <= 1'b0;
                                    proc_count_reg[p_reg]    <= '0;
                                    state_reg <= S_DONE;
                                end
                            end
                            CMD_WRITE:
                            begin
                                if (dyn_reg)
                                begin
                                    si_reg   <= cur_count;
                                    left_reg <= PCNT_W'(1);
                                    i_reg    <= PCNT_W'(page_reg);
                                    if ((32'(page_reg) >= MAX_PAGES)
                                        || (32'(page_reg) > 32'(cur_count)))
                                    begin
                                        res_reg.status <= ST_BAD_PAGE;
                                        state_reg      <= S_DONE;
                                    end
                                    else if (32'(page_reg) == 32'(cur_count))
                                    begin
                                        if (cur_count == '0)
                                        begin
                                            f_reg     <= '0;
                                            state_reg <= S_ROOM_RD;
                                        end
                                        else
                                        begin
                                            row_reg   <= cur_file;
                                            state_reg <= S_ROW_RD;
                                        end
                                    end
                                    else
                                        state_reg <= S_PG_RD;
                                end
                                else
                                begin
                                    i_reg <= '0;
                                    if (cur_count == '0)
                                    begin
                                        res_reg.status <= ST_NO_SPACE;
                                        state_reg      <= S_DONE;
                                    end
                                    else
                                        state_reg <= S_WR_RD;
                                end
                            end
                            default:
                            begin
                                // read and remove
                                i_reg <= PCNT_W'(page_reg);
                                if (32'(page_reg) >= 32'(cur_count))
                                begin
                                    res_reg.status <= ST_BAD_PAGE;
                                    state_reg      <= S_DONE;
                                end
                                else
                                    state_reg <= S_PG_RD;
                            end
                        endcase
                    end
                    else if (last_p)
                    begin
                        res_reg.status <= ST_UNKNOWN;
                        state_reg      <= S_DONE;
                    end
                    else
                        p_reg <= p_reg + PROC_W'(1);
                end

                // count free frames of each active file
                S_ROOM_RD:
                begin
                    state_reg <= S_ROOM_WAIT;
                end
                S_ROOM_WAIT:
                begin
                    word_reg  <= q_room;
                    cnt_reg   <= '0;
                    ch_reg    <= '0;
                    state_reg <= S_ROOM_CNT;
                end
                S_ROOM_CNT:
                begin
                    if (ch_reg == CH_W'(NUM_CHUNKS - 1))
                    begin
                        best_reg  <= best_n;
                        bestc_reg <= bestc_n;
                        if (!f_last)
                        begin
                            f_reg     <= f_reg + FILE_W'(1);
                            state_reg <= S_ROOM_RD;
                        end
                        else if (cmd_reg == CMD_START)
                        begin
                            if (32'(bestc_n) < 32'(need_w))
                            begin
                                res_reg.status <= ST_NO_SPACE;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                proc_valid_reg[p_reg]    <= 1'b1;
                                proc_ident_reg[p_reg]    <= pid_reg;
                                proc_has_file_reg[p_reg] <= 1'b1;
                                proc_file_reg[p_reg]     <= best_n;
                                proc_count_reg[p_reg]    <= need_w;
                                row_reg   <= best_n;
                                si_reg    <= '0;
                                left_reg  <= need_w;
                                state_reg <= S_ROW_RD;
                            end
                        end
                        else
                        begin
                            // first dynamic write picks the file
                            proc_file_reg[p_reg]     <= best_n;
                            proc_has_file_reg[p_reg] <= 1'b1;
                            row_reg   <= best_n;
                            state_reg <= S_ROW_RD;
                        end
                    end
                    else
                    begin
                        cnt_reg <= room_tot;
                        ch_reg  <= ch_reg + CH_W'(1);
                    end
                end

                // fetch the bitmap row of the working file
                S_ROW_RD:
                begin
                    state_reg <= S_ROW_WAIT;
                end
                S_ROW_WAIT:
                begin
                    b_reg     <= '0;
                    found_reg <= 1'b0;
                    i_reg     <= '0;
                    case (cmd_reg)
                        CMD_CLOSE:
                        begin
                            word_reg <= q_row;
                            if (cur_count == '0)
                                state_reg <= S_ROW_WB;
                            else
                                state_reg <= S_CLOSE_RD;
                        end
                        CMD_REMOVE:
                        begin
                            word_reg  <= q_row & ~(FRAMES_PER_FILE'(1) << fr_reg);
                            state_reg <= S_ROW_WB;
                        end
                        default:
                        begin
                            word_reg  <= q_row;
                            state_reg <= S_ALLOC;
                        end
                    endcase
                end

                // take the lowest free frames, one bit per cycle
                S_ALLOC:
                begin
                    if (alloc_hit)
                    begin
                        word_reg[b_reg] <= 1'b1;
                        si_reg          <= si_reg + PCNT_W'(1);
                        left_reg        <= left_reg - PCNT_W'(1);
                        if (!found_reg)
                        begin
                            first_reg <= b_reg;
                            found_reg <= 1'b1;
                        end
                    end
                    if (alloc_end)
                        state_reg <= S_ROW_WB;
                    else
                        b_reg <= b_reg + FRAME_W'(1);
                end

                // write the row back and finish the request
                S_ROW_WB:
                begin
                    row_valid_reg[row_reg] <= 1'b1;
                    state_reg <= S_DONE;
                    case (cmd_reg)
                        CMD_START:
                        begin
                            res_reg.file_index  <= FIDX_W'(row_reg);
                            res_reg.frame_index <= found_reg ? FRIDX_W'(first_reg) : '0;
                        end
                        CMD_WRITE:
                        begin
                            if (found_reg)
                            begin
                                proc_count_reg[p_reg] <= cur_count + PCNT_W'(1);
                                res_reg.file_index    <= FIDX_W'(row_reg);
                                res_reg.frame_index   <= FRIDX_W'(first_reg);
                            end
                            else
                                res_reg.status <= ST_NO_SPACE;
                        end
                        CMD_CLOSE:
                        begin
                            proc_valid_reg[p_reg]    <= 1'b0;
                            proc_has_file_reg[p_reg] <= 1'b0;
                            proc_count_reg[p_reg]    <= '0;
                        end
                        default:
                        begin
                            proc_count_reg[p_reg] <= cur_count - PCNT_W'(1);
                        end
                    endcase
                end

                // close frees every frame of the process
                S_CLOSE_RD:
                begin
                    state_reg <= S_CLOSE_WAIT;
                end
                S_CLOSE_WAIT:
                begin
                    word_reg[q_frame] <= 1'b0;
                    if (i_last)
                        state_reg <= S_ROW_WB;
                    else
                    begin
                        i_reg     <= i_reg + PCNT_W'(1);
                        state_reg <= S_CLOSE_RD;
                    end
                end

                // fixed write: first unwritten slot
                S_WR_RD:
                begin
                    state_reg <= S_WR_WAIT;
                end
                S_WR_WAIT:
                begin
                    if (q_unw)
                    begin
                        res_reg.file_index  <= FIDX_W'(cur_file);
                        res_reg.frame_index <= FRIDX_W'(q_frame);
                        state_reg <= S_DONE;
                    end
                    else if (i_last)
                    begin
                        res_reg.status <= ST_NO_SPACE;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + PCNT_W'(1);
                        state_reg <= S_WR_RD;
                    end
                end

                // one addressed slot: rewrite, read or remove
                S_PG_RD:
                begin
                    state_reg <= S_PG_WAIT;
                end
                S_PG_WAIT:
                begin
                    fr_reg <= q_frame;
                    if (cmd_reg == CMD_WRITE)
                    begin
                        res_reg.file_index  <= FIDX_W'(cur_file);
                        res_reg.frame_index <= FRIDX_W'(q_frame);
                        state_reg <= S_DONE;
                    end
                    else if (q_unw)
                    begin
                        res_reg.status <= ST_UNWRITTEN;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        res_reg.file_index  <= FIDX_W'(cur_file);
                        res_reg.frame_index <= FRIDX_W'(q_frame);
                        if (cmd_reg == CMD_READ)
                            state_reg <= S_DONE;
                        else if (i_last)
                            state_reg <= S_TAIL;
                        else
                            state_reg <= S_SH_RD;
                    end
                end

                // later slots move down one place
                S_SH_RD:
                begin
                    state_reg <= S_SH_WAIT;
                end
                S_SH_WAIT:
                begin
                    i_reg <= i_reg + PCNT_W'(1);
                    if ((32'(i_reg) + 2) < 32'(cur_count))
                        state_reg <= S_SH_RD;
                    else
                        state_reg <= S_TAIL;
                end

                // dynamic frees the frame, fixed parks it at the end
                S_TAIL:
                begin
                    if (dyn_reg)
                    begin
                        row_reg   <= cur_file;
                        state_reg <= S_ROW_RD;
                    end
                    else
                        state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (take)
                        state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/swap_frame_allocator.sv]
// ----------------------------------------------------------------------------
// swap_frame_allocator
// Swap frame manager: per-file free-frame bitmaps and per-process page slots.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  cfg       cfg_we cfg_index cfg_data                 in, write only
//  cmd       cmd_valid cmd_stall command process_id    in, one request
//            page_number
//  rsp       rsp_valid rsp_stall status file_index     out, one result
//            frame_index                               per request
//
//  One request at a time: the table scan takes one entry a cycle, the
//  roomiest-file count 8 bits a cycle per file, the frame scan one bit a
//  cycle, and each slot access a read state then a wait state on the slot
//  memory port. Reset leaves the slot memory undefined and needs no clearing
//  pass. A result held by rsp_stall does not block the next request; only the
//  result after it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_frame_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sfa_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [sfa_pkg::CFG_DW-1:0]    cfg_data,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire logic [sfa_pkg::CMD_W-1:0]     command,
    input  wire logic [sfa_pkg::PID_W-1:0]     process_id,
    input  wire logic [sfa_pkg::PGN_W-1:0]     page_number,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [sfa_pkg::STATUS_W-1:0]       status,
    output logic [sfa_pkg::FIDX_W-1:0]         file_index,
    output logic [sfa_pkg::FRIDX_W-1:0]        frame_index
);
    import sfa_pkg::*;

    cfg_t       cfg_reg;
    req_t       req;
    res_t       eng_res;
    eng_stat_t  eng_stat;
    res_t       rsp_reg;
    logic       rsp_valid_reg;
    logic       take;
    logic       go;

    logic                       map_we;
    logic [FILE_W-1:0]          map_waddr;
    logic [FRAMES_PER_FILE-1:0] map_wdata;
    logic [FILE_W-1:0]          map_raddr;
    logic [FRAMES_PER_FILE-1:0] map_rdata;
    logic                       slot_we;
    logic [SLOT_AW-1:0]         slot_waddr;
    logic [SLOT_DW-1:0]         slot_wdata;
    logic [SLOT_AW-1:0]         slot_raddr;
    logic [SLOT_DW-1:0]         slot_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dyn   <= 1'b0;
            cfg_reg.fpp   <= 7'd4;
            cfg_reg.files <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:  cfg_reg.dyn   <= cfg_data[0];
                CFG_FPP:   cfg_reg.fpp   <= cfg_data[6:0];
                CFG_FILES: cfg_reg.files <= cfg_data[2:0];
                default:   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    // request side
    assign cmd_stall       = !eng_stat.idle;
    assign go              = cmd_valid && !cmd_stall;
    assign req.command     = command;
    assign req.process_id  = process_id;
    assign req.page_number = page_number;

    // result register
    assign take = eng_stat.done && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else if (take)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_reg       <= eng_res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_reg.status;
    assign file_index  = rsp_reg.file_index;
    assign frame_index = rsp_reg.frame_index;

    // free-frame bitmaps, one row per file
    sfa_ram #(
        .WIDTH (FRAMES_PER_FILE),
        .DEPTH (NUM_FILES)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // page slots: frame and unwritten flag
    sfa_ram #(
        .WIDTH (SLOT_DW),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    sfa_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .go         (go),
        .req        (req),
        .take       (take),
        .stat       (eng_stat),
        .res        (eng_res),
        .map_we     (map_we),
        .map_waddr  (map_waddr),
        .map_wdata  (map_wdata),
        .map_raddr  (map_raddr),
        .map_rdata  (map_rdata),
        .slot_we    (slot_we),
        .slot_waddr (slot_waddr),
        .slot_wdata (slot_wdata),
        .slot_raddr (slot_raddr),
        .slot_rdata (slot_rdata)
    );

endmodule

`default_nettype wire

[rtl/core/sfa_checker.sv]
// ----------------------------------------------------------------------------
// sfa_checker
// Port-level checks of the swap frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_stall,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_stall,
    input wire logic [sfa_pkg::STATUS_W-1:0]  status,
    input wire logic [sfa_pkg::FIDX_W-1:0]    file_index,
    input wire logic [sfa_pkg::FRIDX_W-1:0]   frame_index
);
    import sfa_pkg::*;

    // held result keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status)
            && $stable(file_index) && $stable(frame_index)))
        else $error("result changed while stalled");

    // a failed request carries no location
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != ST_OK)) |-> ((file_index == '0) && (frame_index == '0)))
        else $error("location on failed result");

    // only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_TABLE_FULL))
        else $error("undefined status code");

    // one request at a time
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("second request taken while busy");

endmodule

bind swap_frame_allocator sfa_checker u_sfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .file_index  (file_index),
    .frame_index (frame_index)
);

`default_nettype wire

[test/swap_frame_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_frame_allocator_test
// Self-checking bench for the swap frame allocator. A short table of directed
// requests is followed by constrained-by-hand random traffic across several
// register settings and idle/stall patterns. Typed directed rows are checked
// against the table, the rest against a predictor of bitmaps and page tables.
// ----------------------------------------------------------------------------
module swap_frame_allocator_test;

    import sfa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_LEN    = 3000;
    localparam int DIR_N       = 25;
    localparam int POOL_N      = 6;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [PID_W-1:0]    pid;
        logic [PGN_W-1:0]    page;
        bit                  typed;
        logic [STATUS_W-1:0] st;
        logic [FIDX_W-1:0]   fi;
        logic [FRIDX_W-1:0]  fr;
    } dir_row_t;

    // dut ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [CMD_W-1:0]    command = '0;
    logic [PID_W-1:0]    process_id = '0;
    logic [PGN_W-1:0]    page_number = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [FIDX_W-1:0]   file_index;
    logic [FRIDX_W-1:0]  frame_index;

    swap_frame_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .process_id  (process_id),
        .page_number (page_number),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .file_index  (file_index),
        .frame_index (frame_index)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // predictor copy of the register settings
    bit         pr_dyn = 1'b0;
    logic [6:0] pr_fpp = 7'd4;
    logic [2:0] pr_files = 3'd4;

    // predictor copy of bitmaps and process tables
    logic [FRAMES_PER_FILE-1:0] pr_map [NUM_FILES];
    bit                         pr_live [MAX_PROCS];
    logic [PID_W-1:0]           pr_ident [MAX_PROCS];
    logic [FILE_W-1:0]          pr_file [MAX_PROCS];
    bit                         pr_has_file [MAX_PROCS];
    int                         pr_count [MAX_PROCS];
    logic [FRAME_W-1:0]         pr_slot [MAX_PROCS][MAX_PAGES];
    bit                         pr_unw [MAX_PROCS][MAX_PAGES];

    res_t       expected_results [$];
    int         cycles = 0;
    int         mismatches = 0;
    int         results_checked = 0;
    int         requests_sent = 0;
    int         settings_used = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_cycles = 0;
    bit         hold_req = 1'b0;
    bit         hold_seen = 1'b0;
    logic [PID_W-1:0] pid_pool [POOL_N];
    dir_row_t   dir_tab [0:DIR_N-1];

    function automatic int active_files();
        if (pr_files < 3'd1)
            return 1;
        if (pr_files > NUM_FILES)
            return NUM_FILES;
        return int'(pr_files);
    endfunction

    function automatic int free_frames(int f);
        return FRAMES_PER_FILE - $countones(pr_map[f]);
    endfunction

    function automatic int roomiest();
        int best;
        best = 0;
        for (int f = 1; f < active_files(); f++)
            if (free_frames(f) > free_frames(best))
                best = f;
        return best;
    endfunction

    function automatic int lowest_free(int f);
        for (int i = 0; i < FRAMES_PER_FILE; i++)
            if (!pr_map[f][i])
                return i;
        return FRAMES_PER_FILE;
    endfunction

    function automatic int lookup_proc(logic [PID_W-1:0] pid);
        for (int p = 0; p < MAX_PROCS; p++)
            if (pr_live[p] && pr_ident[p] == pid)
                return p;
        return MAX_PROCS;
    endfunction

    // advance the allocator state by one request and return its result
    function automatic res_t allocate_step(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                           logic [PGN_W-1:0] page);
        res_t r;
        int   p;
        int   n;
        int   f;
        int   fr;
        int   need;
        int   i;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_START)
        begin
            p = 0;
            while (p < MAX_PROCS && pr_live[p])
                p++;
            if (p >= MAX_PROCS)
                r.status = ST_TABLE_FULL;
            else if (pr_dyn)
            begin
                pr_live[p] = 1; pr_ident[p] = pid;
                pr_has_file[p] = 0; pr_file[p] = '0; pr_count[p] = 0;
            end
            else
            begin
                need = (pr_fpp > MAX_PAGES) ? MAX_PAGES : int'(pr_fpp);
                f = roomiest();
                if (free_frames(f) < need)
                    r.status = ST_NO_SPACE;
                else
                begin
                    pr_live[p] = 1; pr_ident[p] = pid;
                    pr_has_file[p] = 1; pr_file[p] = FILE_W'(f); pr_count[p] = need;
                    for (i = 0; i < need; i++)
                    begin
                        fr = lowest_free(f);
                        pr_map[f][fr] = 1'b1;
                        pr_slot[p][i] = FRAME_W'(fr);
                        pr_unw[p][i] = 1;
                    end
                    r.file_index = FIDX_W'(f);
                    r.frame_index = need ? pr_slot[p][0] : '0;
                end
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            for (i = 0; i < NUM_FILES; i++)
                pr_map[i] = '0;
            for (i = 0; i < MAX_PROCS; i++)
            begin
                pr_live[i] = 0; pr_has_file[i] = 0; pr_count[i] = 0;
            end
        end
        else if (cmd <= CMD_REMOVE)
        begin
            p = lookup_proc(pid);
            if (p >= MAX_PROCS)
                r.status = ST_UNKNOWN;
            else if (cmd == CMD_CLOSE)
            begin
                if (pr_has_file[p])
                    for (i = 0; i < pr_count[p]; i++)
                        pr_map[pr_file[p]][pr_slot[p][i]] = 1'b0;
                pr_live[p] = 0; pr_has_file[p] = 0; pr_count[p] = 0;
            end
            else if (cmd == CMD_WRITE)
            begin
                n = pr_count[p];
                if (pr_dyn)
                begin
                    if (page >= MAX_PAGES || page > n)
                        r.status = ST_BAD_PAGE;
                    else if (page == n)
                    begin
                        if (n == 0)
                        begin
                            pr_file[p] = FILE_W'(roomiest());
                            pr_has_file[p] = 1;
                        end
                        f = int'(pr_file[p]);
                        fr = lowest_free(f);
                        if (fr >= FRAMES_PER_FILE)
                            r.status = ST_NO_SPACE;
                        else
                        begin
                            pr_map[f][fr] = 1'b1;
                            pr_slot[p][n] = FRAME_W'(fr);
                            pr_unw[p][n] = 0;
                            pr_count[p] = n + 1;
                            r.file_index = FIDX_W'(f);
                            r.frame_index = FRIDX_W'(fr);
                        end
                    end
                    else
                    begin
                        pr_unw[p][page] = 0;
                        r.file_index = pr_file[p];
                        r.frame_index = pr_slot[p][page];
                    end
                end
                else
                begin
                    i = 0;
                    while (i < n && !pr_unw[p][i])
                        i++;
                    if (i >= n)
                        r.status = ST_NO_SPACE;
                    else
                    begin
                        pr_unw[p][i] = 0;
                        r.file_index = pr_file[p];
                        r.frame_index = pr_slot[p][i];
                    end
                end
            end
            else
            begin
                // read and remove share the lookup
                if (page >= pr_count[p])
                    r.status = ST_BAD_PAGE;
                else if (pr_unw[p][page])
                    r.status = ST_UNWRITTEN;
                else
                begin
                    f = int'(pr_file[p]);
                    fr = int'(pr_slot[p][page]);
                    r.file_index = FIDX_W'(f);
                    r.frame_index = FRIDX_W'(fr);
                    if (cmd == CMD_REMOVE)
                    begin
                        n = pr_count[p];
                        for (i = int'(page); i + 1 < n; i++)
                        begin
                            pr_slot[p][i] = pr_slot[p][i + 1];
                            pr_unw[p][i] = pr_unw[p][i + 1];
                        end
                        pr_count[p] = n - 1;
                        if (pr_dyn)
                            pr_map[f][fr] = 1'b0;
                        else
                        begin
                            // fixed mode keeps the frame as an unwritten tail slot
                            pr_slot[p][n - 1] = FRAME_W'(fr);
                            pr_unw[p][n - 1] = 1;
                            pr_count[p] = n;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // one register write, mirrored in the predictor
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MODE)
            pr_dyn = data[0];
        else if (idx == CFG_FPP)
            pr_fpp = data;
        else if (idx == CFG_FILES)
            pr_files = data[2:0];
    endtask

    // wait for the block to go quiet, then load a new setting
    task automatic load_setting(bit dyn, logic [6:0] fpp, logic [2:0] files);
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        write_reg(CFG_MODE, {6'd0, dyn});
        write_reg(CFG_FPP, fpp);
        write_reg(CFG_FILES, {4'd0, files});
        settings_used++;
    endtask

    // offer one request and hold it until the handshake
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                logic [PGN_W-1:0] page, bit typed, res_t typed_res);
        int   gap;
        res_t r;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= cmd;
        process_id <= pid;
        page_number <= page;
        do
            @(posedge clk);
        while (cmd_stall);
        r = allocate_step(cmd, pid, page);
        expected_results.push_back(typed ? typed_res : r);
        requests_sent++;
    endtask

    // random request, mostly aimed at live processes and valid pages
    task automatic send_random();
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] pid;
        logic [PGN_W-1:0] page;
        int               w;
        int               p;
        pid = pid_pool[$urandom_range(POOL_N - 1)];
        page = PGN_W'($urandom);
        w = $urandom_range(99);
        if (w < 8)
        begin
            cmd = CMD_W'($urandom);
            pid = PID_W'($urandom);
        end
        else if (w < 26)
            cmd = CMD_START;
        else if (w < 34)
            cmd = CMD_CLOSE;
        else if (w < 64)
            cmd = CMD_WRITE;
        else if (w < 84)
            cmd = CMD_READ;
        else if (w < 98)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_CLEAR;
        p = lookup_proc(pid);
        if (p < MAX_PROCS && $urandom_range(9) < 8)
        begin
            if (cmd == CMD_WRITE && pr_dyn)
                page = ($urandom_range(3) != 0 || pr_count[p] == 0) ? PGN_W'(pr_count[p])
                       : PGN_W'($urandom_range(pr_count[p] - 1));
            else if ((cmd == CMD_READ || cmd == CMD_REMOVE) && pr_count[p] > 0)
                page = PGN_W'($urandom_range(pr_count[p] - 1));
        end
        send_request(cmd, pid, page, 1'b0, '0);
    endtask

    // response side: random stall, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_cycles <= HOLD_LEN;
            rsp_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            rsp_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d file %0d frame %0d",
                             status, file_index, frame_index);
            end
            else
            begin
                e = expected_results.pop_front();
                results_checked++;
                if (status !== e.status || file_index !== e.file_index
                    || frame_index !== e.frame_index)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 results_checked, e.status, e.file_index, e.frame_index,
                                 status, file_index, frame_index);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n) send_random();
    endtask

    initial
    begin
        for (int f = 0; f < NUM_FILES; f++)
            pr_map[f] = '0;
        for (int p = 0; p < MAX_PROCS; p++)
        begin
            pr_live[p] = 0; pr_has_file[p] = 0; pr_count[p] = 0;
        end
        pid_pool[0] = 16'h0000;
        pid_pool[1] = 16'hFFFF;
        for (int k = 2; k < POOL_N; k++)
            pid_pool[k] = PID_W'($urandom);

        // directed table: typed rows are obvious by inspection
        dir_tab = '{
            '{CMD_READ,   16'h0005, 6'd0,  1, ST_UNKNOWN,    2'd0, 6'd0},
            '{CMD_CLOSE,  16'h0005, 6'd0,  1, ST_UNKNOWN,    2'd0, 6'd0},
            '{CMD_START,  16'h0000, 6'd0,  1, ST_OK,         2'd0, 6'd0},
            '{CMD_START,  16'hFFFF, 6'd63, 1, ST_OK,         2'd1, 6'd0},
            '{CMD_WRITE,  16'h0000, 6'd63, 1, ST_OK,         2'd0, 6'd0},
            '{CMD_READ,   16'h0000, 6'd0,  1, ST_OK,         2'd0, 6'd0},
            '{CMD_READ,   16'h0000, 6'd1,  1, ST_UNWRITTEN,  2'd0, 6'd0},
            '{CMD_READ,   16'h0000, 6'd4,  1, ST_BAD_PAGE,   2'd0, 6'd0},
            '{CMD_REMOVE, 16'h0000, 6'd1,  1, ST_UNWRITTEN,  2'd0, 6'd0},
            '{CMD_START,  16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_WRITE,  16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_WRITE,  16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_WRITE,  16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_WRITE,  16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_REMOVE, 16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_READ,   16'h0000, 6'd3,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_WRITE,  16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_CLOSE,  16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_READ,   16'h0000, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_CLOSE,  16'hFFFF, 6'd0,  0, ST_OK,         2'd0, 6'd0},
            '{CMD_SPARE6, 16'hAAAA, 6'd21, 1, ST_OK,         2'd0, 6'd0},
            '{CMD_SPARE7, 16'h5555, 6'd42, 1, ST_OK,         2'd0, 6'd0},
            '{CMD_CLEAR,  16'h0000, 6'd0,  1, ST_OK,         2'd0, 6'd0},
            '{CMD_READ,   16'h0000, 6'd0,  1, ST_UNKNOWN,    2'd0, 6'd0},
            '{CMD_WRITE,  16'hFFFF, 6'd0,  1, ST_UNKNOWN,    2'd0, 6'd0}
        };

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset settings
        for (int i = 0; i < DIR_N; i++)
            send_request(dir_tab[i].cmd, dir_tab[i].pid, dir_tab[i].page, dir_tab[i].typed,
                         '{dir_tab[i].st, dir_tab[i].fi, dir_tab[i].fr});
        random_phase(200, 0, 0);

        // dynamic, all files, idle sender
        load_setting(1'b1, 7'd4, 3'd4);
        random_phase(250, 75, 0);

        // whole-file reservations, stalling receiver with one long hold-off
        load_setting(1'b0, 7'd64, 3'd4);
        hold_req = 1'b1;
        random_phase(200, 0, 75);

        // dynamic on a single file, both sides idle
        load_setting(1'b1, 7'd1, 3'd1);
        random_phase(250, 30, 30);

        // zero reservation and a files count of zero
        load_setting(1'b0, 7'd0, 3'd0);
        random_phase(150, 0, 0);

        // saturating reservation and too many files
        load_setting(1'b0, 7'd127, 3'd7);
        random_phase(150, 75, 0);

        // small reservation over two files
        load_setting(1'b0, 7'd1, 3'd2);
        random_phase(150, 30, 30);

        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run covered %0d requests over %0d register settings plus reset defaults",
                 requests_sent, settings_used);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
